FILE: sv/uer_pkg.sv
// Shared types, codes and reset values for the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned DivBits = 16;

  localparam logic [2:0] CFG_TRIGGER_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_RISE_TIMEOUT   = 3'd1;
  localparam logic [2:0] CFG_HIGH_TIMEOUT   = 3'd2;
  localparam logic [2:0] CFG_US_PER_CM      = 3'd3;
  localparam logic [2:0] CFG_MAX_DISTANCE   = 3'd4;
  localparam logic [2:0] CFG_MISS_AS_MAX    = 3'd5;
  localparam logic [2:0] CFG_INVALID_DIST   = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_STUCK   = 2'd1;
  localparam logic [1:0] ST_NO_ECHO = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic [7:0]  RST_TRIGGER_WIDTH = 8'd12;
  localparam logic [15:0] RST_RISE_TIMEOUT  = 16'd5000;
  localparam logic [15:0] RST_HIGH_TIMEOUT  = 16'd30000;
  localparam logic [7:0]  RST_US_PER_CM     = 8'd58;
  localparam logic [15:0] RST_MAX_DISTANCE  = 16'd400;
  localparam logic [15:0] RST_INVALID_DIST  = 16'd65535;
  localparam logic [15:0] TRIG_LOW_TICKS    = 16'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_RISE,
    PH_MEASURE,
    PH_DIVIDE
  } phase_t;

  typedef struct packed {
    logic [7:0]  trigger_width_us;
    logic [15:0] rise_timeout_us;
    logic [15:0] high_timeout_us;
    logic [7:0]  us_per_cm;
    logic [15:0] max_range_cm;
    logic        miss_as_max;
    logic [15:0] invalid_range_cm;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] range_cm;
    logic        distance_valid;
    logic        done_res;
    logic        busy_res;
    logic        trigger_level;
  } res_t;

endpackage

FILE: sv/uer_div.sv
// Bit-serial restoring divider: echo width over microseconds per centimeter.
module uer_div (
  input  logic              clk,
  input  logic              rst_n,
  input  uer_pkg::div_req_t req,
  output uer_pkg::div_rsp_t rsp
);

  logic        active_r, active_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [7:0]  dv_r, dv_nxt;
  logic [8:0]  trial;
  logic        ge;

  assign trial = {rem_r, quo_r[uer_pkg::DivBits-1]};
  assign ge    = trial >= {1'b0, dv_r};

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dv_nxt     = dv_r;
    if (req.start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      rem_nxt    = '0;
      quo_nxt    = req.dividend;
      // A zero divisor divides by one.
      dv_nxt     = (req.divisor == 8'd0) ? 8'd1 : req.divisor;
    end else if (active_r) begin
      rem_nxt = ge ? 8'(trial - {1'b0, dv_r}) : trial[7:0];
      quo_nxt = {quo_r[uer_pkg::DivBits-2:0], ge};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(uer_pkg::DivBits - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dv_r  <= dv_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: sv/uer_ctrl.sv
// Measurement sequencer: one step per microsecond tick, plus the result hold.
module uer_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              start_req,
  input  logic              echo_level,
  input  uer_pkg::cfg_t     cfg,
  input  uer_pkg::div_rsp_t div_rsp,
  output uer_pkg::div_req_t div_req,
  output logic              res_valid,
  output uer_pkg::res_t     res,
  output logic              dividing
);

  uer_pkg::phase_t phase_r, phase_nxt, ph_eff;
  logic [15:0] elapsed_r, elapsed_nxt, el_eff, el_inc;
  logic [15:0] last_dist_r;
  logic [1:0]  last_status_r;
  logic        last_valid_r;
  logic        trig, fin, fin_valid, div_go, cm_bad;
  logic [1:0]  fin_status;
  logic [15:0] fin_dist, no_echo_dist;

  always_comb begin
    ph_eff = phase_r;
    el_eff = elapsed_r;
    if (phase_r == uer_pkg::PH_IDLE && start_req) begin
      ph_eff = uer_pkg::PH_WAIT_IDLE;
      el_eff = '0;
    end
  end

  assign el_inc       = el_eff + 16'd1;
  assign cm_bad       = (div_rsp.quotient == 16'd0) ||
                        (div_rsp.quotient > cfg.max_range_cm);
  assign no_echo_dist = cfg.miss_as_max ? cfg.max_range_cm : cfg.invalid_range_cm;
  assign dividing     = (phase_r == uer_pkg::PH_DIVIDE);

  // Next phase and elapsed time.
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    if (phase_r == uer_pkg::PH_DIVIDE) begin
      if (div_rsp.done) begin
        phase_nxt   = uer_pkg::PH_IDLE;
        elapsed_nxt = '0;
      end
    end else if (step) begin
      phase_nxt   = ph_eff;
      elapsed_nxt = el_eff;
      case (ph_eff)
        uer_pkg::PH_IDLE: begin
        end
        uer_pkg::PH_WAIT_IDLE: begin
          if (!echo_level) begin
            phase_nxt   = uer_pkg::PH_TRIG_LOW;
            elapsed_nxt = '0;
          end else if (el_eff >= cfg.high_timeout_us) begin
            phase_nxt   = uer_pkg::PH_IDLE;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = el_inc;
          end
        end
        uer_pkg::PH_TRIG_LOW: begin
          elapsed_nxt = el_inc;
          if (el_inc >= uer_pkg::TRIG_LOW_TICKS) begin
            phase_nxt   = uer_pkg::PH_TRIG_HIGH;
            elapsed_nxt = '0;
          end
        end
        uer_pkg::PH_TRIG_HIGH: begin
          elapsed_nxt = el_inc;
          if (el_inc >= {8'd0, cfg.trigger_width_us}) begin
            phase_nxt   = uer_pkg::PH_WAIT_RISE;
            elapsed_nxt = '0;
          end
        end
        uer_pkg::PH_WAIT_RISE: begin
          if (echo_level) begin
            phase_nxt   = uer_pkg::PH_MEASURE;
            elapsed_nxt = '0;
          end else if (el_eff >= cfg.rise_timeout_us) begin
            phase_nxt   = uer_pkg::PH_IDLE;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = el_inc;
          end
        end
        uer_pkg::PH_MEASURE: begin
          if (!echo_level) begin
            phase_nxt = uer_pkg::PH_DIVIDE;
          end else if (el_inc >= cfg.high_timeout_us) begin
            phase_nxt   = uer_pkg::PH_IDLE;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = el_inc;
          end
        end
        default: begin
          phase_nxt   = uer_pkg::PH_IDLE;
          elapsed_nxt = '0;
        end
      endcase
    end
  end

  // Trigger, finish and divider launch.
  always_comb begin
    trig       = 1'b0;
    fin        = 1'b0;
    fin_status = uer_pkg::ST_OK;
    fin_valid  = 1'b0;
    fin_dist   = cfg.invalid_range_cm;
    div_go     = 1'b0;
    if (phase_r == uer_pkg::PH_DIVIDE) begin
      if (div_rsp.done) begin
        fin = 1'b1;
        if (cm_bad) begin
          fin_status = uer_pkg::ST_RANGE;
        end else begin
          fin_valid = 1'b1;
          fin_dist  = div_rsp.quotient;
        end
      end
    end else if (step) begin
      case (ph_eff)
        uer_pkg::PH_WAIT_IDLE: begin
          if (echo_level && el_eff >= cfg.high_timeout_us) begin
            fin        = 1'b1;
            fin_status = uer_pkg::ST_STUCK;
          end
        end
        uer_pkg::PH_TRIG_HIGH: begin
          trig = 1'b1;
        end
        uer_pkg::PH_WAIT_RISE: begin
          if (!echo_level && el_eff >= cfg.rise_timeout_us) begin
            fin        = 1'b1;
            fin_status = uer_pkg::ST_NO_ECHO;
            fin_valid  = cfg.miss_as_max;
            fin_dist   = no_echo_dist;
          end
        end
        uer_pkg::PH_MEASURE: begin
          if (!echo_level) begin
            div_go = 1'b1;
          end else if (el_inc >= cfg.high_timeout_us) begin
            fin        = 1'b1;
            fin_status = uer_pkg::ST_NO_ECHO;
            fin_valid  = cfg.miss_as_max;
            fin_dist   = no_echo_dist;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign div_req.start    = div_go;
  assign div_req.dividend = el_inc;
  assign div_req.divisor  = cfg.us_per_cm;

  // The tick that ends the echo reports only once the quotient is in.
  assign res_valid          = (step && !div_go) || (dividing && div_rsp.done);
  assign res.trigger_level  = trig;
  assign res.busy_res       = (phase_nxt != uer_pkg::PH_IDLE);
  assign res.done_res       = fin;
  assign res.distance_valid = fin ? fin_valid : last_valid_r;
  assign res.range_cm       = fin ? fin_dist : last_dist_r;
  assign res.status         = fin ? fin_status : last_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= uer_pkg::PH_IDLE;
      elapsed_r     <= '0;
      last_dist_r   <= uer_pkg::RST_INVALID_DIST;
      last_status_r <= uer_pkg::ST_OK;
      last_valid_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      if (fin) begin
        last_dist_r   <= fin_dist;
        last_status_r <= fin_status;
        last_valid_r  <= fin_valid;
      end
    end
  end

endmodule

FILE: sv/ultrasonic_echo_ranger_unit.sv
// Top level of the ultrasonic echo ranger: ports, registers and output word.
//
// Each input word is one microsecond tick: start request and the sampled echo
// pin. Each accepted word gives exactly one output word: trigger pin level,
// busy, done, and the last finished measurement (valid flag, distance in cm,
// status), which is held between measurements.
// An ordinary tick is accepted and answered in the same cycle; its output word
// appears in the output register on the next cycle. The tick on which the
// echo falls starts a bit-serial divider that retires one quotient bit per
// cycle; its output word appears once the quotient is in, and no input word
// is taken meanwhile.
// Up to one word per cycle is sustained while the receiver keeps up and no
// divide runs; a stalled output word holds, and a new input word is taken only
// in the cycle the register drains or while it is empty.
// Configuration writes land in the register on cfg_we and belong to idle time.
// Synchronous reset clears the sequencer to idle, empties the output register,
// and restores every configuration register to its default value.
module ultrasonic_echo_ranger_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] start_req, [1] echo_level, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] trigger_level, [1] busy_res, [2] done_res, [3] distance_valid,
  // [19:4] range_cm, [21:20] status, rest zero
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  uer_pkg::cfg_t     cfg_r, cfg_nxt;
  uer_pkg::div_req_t div_req;
  uer_pkg::div_rsp_t div_rsp;
  uer_pkg::res_t     res, out_res_r;
  logic              res_valid, dividing, in_fire, out_valid_r, out_valid_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        uer_pkg::CFG_TRIGGER_WIDTH:  cfg_nxt.trigger_width_us = cfg_wdata[7:0];
        uer_pkg::CFG_RISE_TIMEOUT:   cfg_nxt.rise_timeout_us  = cfg_wdata;
        uer_pkg::CFG_HIGH_TIMEOUT:   cfg_nxt.high_timeout_us  = cfg_wdata;
        uer_pkg::CFG_US_PER_CM:      cfg_nxt.us_per_cm        = cfg_wdata[7:0];
        uer_pkg::CFG_MAX_DISTANCE:   cfg_nxt.max_range_cm     = cfg_wdata;
        uer_pkg::CFG_MISS_AS_MAX:    cfg_nxt.miss_as_max      = cfg_wdata[0];
        uer_pkg::CFG_INVALID_DIST:   cfg_nxt.invalid_range_cm = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !dividing && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  uer_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .start_req  (in_tdata[0]),
    .echo_level (in_tdata[1]),
    .cfg        (cfg_r),
    .div_rsp    (div_rsp),
    .div_req    (div_req),
    .res_valid  (res_valid),
    .res        (res),
    .dividing   (dividing)
  );

  uer_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_width_us <= uer_pkg::RST_TRIGGER_WIDTH;
      cfg_r.rise_timeout_us  <= uer_pkg::RST_RISE_TIMEOUT;
      cfg_r.high_timeout_us  <= uer_pkg::RST_HIGH_TIMEOUT;
      cfg_r.us_per_cm        <= uer_pkg::RST_US_PER_CM;
      cfg_r.max_range_cm     <= uer_pkg::RST_MAX_DISTANCE;
      cfg_r.miss_as_max      <= 1'b0;
      cfg_r.invalid_range_cm <= uer_pkg::RST_INVALID_DIST;
      out_valid_r            <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule

FILE: sv/uer_checker.sv
// Port-level checks for the ultrasonic echo ranger, bound to the top level.
module uer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A held output word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output word present after reset");

  // The finishing tick leaves the block idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1])
    else $error("done reported while still busy");

  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1] && !out_tdata[2])
    else $error("trigger high outside a measurement");

  a_bad_status_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[21:20] == uer_pkg::ST_STUCK ||
                   out_tdata[21:20] == uer_pkg::ST_RANGE) |-> !out_tdata[3])
    else $error("failed measurement flagged valid");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/testbench.sv
// Self-checking testbench for the ultrasonic echo ranger: tick stream, register setups, scoreboard.
`timescale 1ns / 1ps

module testbench;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] start_req, [1] echo_level, rest zero
  logic        out_tvalid;
  logic        out_tready;
  // [0] trigger_level, [1] busy_res, [2] done_res, [3] distance_valid,
  // [19:4] range_cm, [21:20] status, rest zero
  logic [23:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  ultrasonic_echo_ranger_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Ranger state as the testbench sees it.
  uer_pkg::cfg_t   setup;
  uer_pkg::phase_t seq_phase;
  logic [15:0]     tick_count;
  logic [15:0]     held_distance;
  logic [1:0]      held_status;
  logic            held_valid;

  uer_pkg::res_t pending_reports[$];
  int            mismatch_count;
  int            measured_ticks;
  int            src_idle_pct;
  int            sink_stall_pct;
  int            hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void reset_ranger_model();
    setup.trigger_width_us = uer_pkg::RST_TRIGGER_WIDTH;
    setup.rise_timeout_us  = uer_pkg::RST_RISE_TIMEOUT;
    setup.high_timeout_us  = uer_pkg::RST_HIGH_TIMEOUT;
    setup.us_per_cm        = uer_pkg::RST_US_PER_CM;
    setup.max_range_cm     = uer_pkg::RST_MAX_DISTANCE;
    setup.miss_as_max      = 1'b0;
    setup.invalid_range_cm = uer_pkg::RST_INVALID_DIST;
    seq_phase     = uer_pkg::PH_IDLE;
    tick_count    = '0;
    held_distance = uer_pkg::RST_INVALID_DIST;
    held_status   = uer_pkg::ST_OK;
    held_valid    = 1'b0;
  endfunction

  function automatic void record_outcome(input logic [1:0] st, input logic valid,
                                         input logic [15:0] cm_val);
    held_status   = st;
    held_valid    = valid;
    held_distance = cm_val;
    seq_phase     = uer_pkg::PH_IDLE;
    tick_count    = '0;
  endfunction

  function automatic void record_no_echo();
    if (setup.miss_as_max) begin
      record_outcome(uer_pkg::ST_NO_ECHO, 1'b1, setup.max_range_cm);
    end else begin
      record_outcome(uer_pkg::ST_NO_ECHO, 1'b0, setup.invalid_range_cm);
    end
  endfunction

  // Advances the ranger by one microsecond tick and returns the output word.
  function automatic uer_pkg::res_t predict_tick(input logic start, input logic echo);
    uer_pkg::res_t r;
    logic [15:0]   now;
    logic [15:0]   cm;
    logic [7:0]    div;
    r = '0;
    if (seq_phase == uer_pkg::PH_IDLE && start) begin
      seq_phase  = uer_pkg::PH_WAIT_IDLE;
      tick_count = '0;
    end
    case (seq_phase)
      uer_pkg::PH_WAIT_IDLE: begin
        if (!echo) begin
          seq_phase  = uer_pkg::PH_TRIG_LOW;
          tick_count = '0;
        end else if (tick_count >= setup.high_timeout_us) begin
          record_outcome(uer_pkg::ST_STUCK, 1'b0, setup.invalid_range_cm);
          r.done_res = 1'b1;
        end else begin
          tick_count = tick_count + 16'd1;
        end
      end
      uer_pkg::PH_TRIG_LOW: begin
        tick_count = tick_count + 16'd1;
        if (tick_count >= uer_pkg::TRIG_LOW_TICKS) begin
          seq_phase  = uer_pkg::PH_TRIG_HIGH;
          tick_count = '0;
        end
      end
      uer_pkg::PH_TRIG_HIGH: begin
        r.trigger_level = 1'b1;
        tick_count = tick_count + 16'd1;
        if (tick_count >= {8'd0, setup.trigger_width_us}) begin
          seq_phase  = uer_pkg::PH_WAIT_RISE;
          tick_count = '0;
        end
      end
      uer_pkg::PH_WAIT_RISE: begin
        if (echo) begin
          seq_phase  = uer_pkg::PH_MEASURE;
          tick_count = '0;
        end else if (tick_count >= setup.rise_timeout_us) begin
          record_no_echo();
          r.done_res = 1'b1;
        end else begin
          tick_count = tick_count + 16'd1;
        end
      end
      uer_pkg::PH_MEASURE: begin
        now = tick_count + 16'd1;
        if (!echo) begin
          // A zero divisor behaves as one.
          div = (setup.us_per_cm == 8'd0) ? 8'd1 : setup.us_per_cm;
          cm  = now / {8'd0, div};
          if (cm == 16'd0 || cm > setup.max_range_cm) begin
            record_outcome(uer_pkg::ST_RANGE, 1'b0, setup.invalid_range_cm);
          end else begin
            record_outcome(uer_pkg::ST_OK, 1'b1, cm);
          end
          r.done_res = 1'b1;
        end else if (now >= setup.high_timeout_us) begin
          record_no_echo();
          r.done_res = 1'b1;
        end else begin
          tick_count = now;
        end
      end
      default: begin
        seq_phase  = uer_pkg::PH_IDLE;
        tick_count = '0;
      end
    endcase
    r.busy_res       = (seq_phase != uer_pkg::PH_IDLE);
    r.distance_valid = held_valid;
    r.range_cm       = held_distance;
    r.status         = held_status;
    return r;
  endfunction

  function automatic uer_pkg::cfg_t make_setup(input int unsigned tw,
                                               input int unsigned rise_to,
                                               input int unsigned high_to,
                                               input int unsigned div,
                                               input int unsigned max_cm,
                                               input int unsigned as_max,
                                               input int unsigned bad_cm);
    uer_pkg::cfg_t c;
    c.trigger_width_us = tw[7:0];
    c.rise_timeout_us  = rise_to[15:0];
    c.high_timeout_us  = high_to[15:0];
    c.us_per_cm        = div[7:0];
    c.max_range_cm     = max_cm[15:0];
    c.miss_as_max      = as_max[0];
    c.invalid_range_cm = bad_cm[15:0];
    return c;
  endfunction

  // Mostly short timings so that many measurements fit, with an occasional extreme.
  function automatic uer_pkg::cfg_t random_setup();
    return make_setup(($urandom_range(9) == 0) ? 255 : $urandom_range(8),
                      ($urandom_range(7) == 0) ? 65535 : $urandom_range(12),
                      ($urandom_range(7) == 0) ? 65535 : $urandom_range(30),
                      $urandom_range(6), $urandom_range(12), $urandom_range(1),
                      $urandom_range(65535));
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_setup(input uer_pkg::cfg_t c);
    write_reg(uer_pkg::CFG_TRIGGER_WIDTH, {8'd0, c.trigger_width_us});
    write_reg(uer_pkg::CFG_RISE_TIMEOUT, c.rise_timeout_us);
    write_reg(uer_pkg::CFG_HIGH_TIMEOUT, c.high_timeout_us);
    write_reg(uer_pkg::CFG_US_PER_CM, {8'd0, c.us_per_cm});
    write_reg(uer_pkg::CFG_MAX_DISTANCE, c.max_range_cm);
    write_reg(uer_pkg::CFG_MISS_AS_MAX, {15'd0, c.miss_as_max});
    write_reg(uer_pkg::CFG_INVALID_DIST, c.invalid_range_cm);
    @(negedge clk);
    cfg_we <= 1'b0;
    setup = c;
  endtask

  // Offers one tick word; tvalid stays high on return so back-to-back words need no
  // second assignment in the same step.
  task automatic send_tick(input logic start, input logic echo);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, echo, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_reports.push_back(predict_tick(start, echo));
  endtask

  task automatic drain_reports();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // One measurement from start to done. The echo is high for stuck_ticks ticks from
  // the start tick, rises rise_delay ticks into the rise wait, and stays high for
  // echo_width ticks. Echo is random while the trigger runs and start is random
  // while busy; the block must ignore both.
  task automatic run_measurement(input int stuck_ticks, input int rise_delay,
                                 input int echo_width);
    int   n_idle;
    int   n_rise;
    int   n_high;
    logic e;
    n_idle = 1;
    n_rise = 0;
    n_high = 0;
    send_tick(1'b1, stuck_ticks > 0);
    measured_ticks++;
    while (seq_phase != uer_pkg::PH_IDLE) begin
      case (seq_phase)
        uer_pkg::PH_WAIT_IDLE: begin
          e = (n_idle < stuck_ticks);
          n_idle++;
        end
        uer_pkg::PH_WAIT_RISE: begin
          e = (n_rise >= rise_delay);
          n_rise++;
        end
        uer_pkg::PH_MEASURE: begin
          e = (n_high < echo_width - 1);
          n_high++;
        end
        default: e = 1'($urandom_range(1));
      endcase
      send_tick(1'($urandom_range(1)), e);
      measured_ticks++;
    end
  endtask

  task automatic test_reset_state();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (3) send_tick(1'b0, 1'($urandom_range(1)));
    run_measurement(3, 0, 59);
    drain_reports();
  endtask

  task automatic test_register_extremes();
    load_setup(make_setup(255, 65535, 65535, 1, 65535, 1, 0));
    run_measurement(0, 3, 20);
    drain_reports();
    load_setup(make_setup(6, 65535, 65535, 255, 65535, 0, 16'h8000));
    run_measurement(2, 0, 260);
    drain_reports();
    load_setup(make_setup(1, 1, 1, 255, 1, 0, 16'h7FFF));
    run_measurement(0, 1, 1);
    run_measurement(0, 2, 1);
    drain_reports();
  endtask

  task automatic test_status_outcomes();
    load_setup(make_setup(3, 4, 10, 2, 4, 0, 16'hA5A5));
    run_measurement(0, 0, 6);
    run_measurement(0, 4, 8);     // rise on the last allowed tick
    run_measurement(0, 5, 6);     // rise too late
    run_measurement(0, 0, 1);     // quotient of zero
    run_measurement(0, 0, 10);    // above the maximum distance
    run_measurement(0, 0, 11);    // echo held too long
    run_measurement(10, 0, 4);    // echo goes idle just in time
    run_measurement(11, 0, 4);    // echo stuck high
    drain_reports();
    load_setup(make_setup(3, 4, 10, 2, 4, 1, 16'h5A5A));
    run_measurement(0, 5, 6);
    run_measurement(0, 0, 11);
    run_measurement(11, 0, 4);
    drain_reports();
  endtask

  task automatic test_zero_settings();
    load_setup(make_setup(0, 0, 0, 0, 3, 0, $urandom_range(65535)));
    run_measurement(1, 0, 1);
    run_measurement(0, 0, 1);
    run_measurement(0, 1, 1);
    run_measurement(0, 0, 2);
    drain_reports();
    load_setup(make_setup(0, 0, 0, 0, 0, 1, $urandom_range(65535)));
    run_measurement(0, 0, 1);
    run_measurement(0, 1, 1);
    drain_reports();
  endtask

  // The receiver holds off long enough that the block fills and stops taking ticks.
  task automatic test_output_hold();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    load_setup(make_setup(2, 6, 20, 1, 12, 0, 16'h1234));
    hold_cycles = 300;
    repeat (4) run_measurement(0, $urandom_range(4), $urandom_range(1, 14));
    drain_reports();
    repeat (2) run_measurement(0, $urandom_range(4), $urandom_range(1, 14));
    drain_reports();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input int tick_goal);
    int goal;
    goal           = measured_ticks + tick_goal;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    while (measured_ticks < goal) begin
      drain_reports();
      load_setup(random_setup());
      repeat (3) begin
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(1, 4)) send_tick(1'b0, 1'($urandom_range(1)));
        end
        case ($urandom_range(9))
          0: run_measurement($urandom_range(1, 40), $urandom_range(6),
                             $urandom_range(1, 20));
          1: run_measurement(0, $urandom_range(10, 20), $urandom_range(1, 20));
          2: run_measurement(0, $urandom_range(4), $urandom_range(25, 40));
          default: run_measurement($urandom_range(3), $urandom_range(8),
                                   $urandom_range(1, 24));
        endcase
      end
    end
    drain_reports();
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
    if (want != seen) begin
      mismatch_count++;
      $display("%0t %s expected %0d actual %0d", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin : check_reports
    uer_pkg::res_t want;
    uer_pkg::res_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = uer_pkg::res_t'(out_tdata[21:0]);
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected word expected none actual %h", $time, out_tdata);
      end else begin
        want = pending_reports.pop_front();
        compare_field("trigger_level", 16'(want.trigger_level),
                      16'(seen.trigger_level));
        compare_field("busy_res", 16'(want.busy_res), 16'(seen.busy_res));
        compare_field("done_res", 16'(want.done_res), 16'(seen.done_res));
        compare_field("distance_valid", 16'(want.distance_valid),
                      16'(seen.distance_valid));
        compare_field("range_cm", want.range_cm, seen.range_cm);
        compare_field("status", 16'(want.status), 16'(seen.status));
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    measured_ticks = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_cycles    = 0;
    reset_ranger_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_register_extremes();
    test_status_outcomes();
    test_zero_settings();
    test_output_hold();
    test_random_traffic(0, 0, 40);
    test_random_traffic(51, 0, 40);
    test_random_traffic(0, 51, 40);
    test_random_traffic(19, 19, 40);

    drain_reports();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
